>>> hw/rtl/spc_pkg.sv
// Shared types and constants of the segmented PID position controller.
// Used by spc_mul, spc_div and segmented_pid_position_controller.
package spc_pkg;

  localparam int unsigned SPC_DUTY_MAX_DEF = 1023;

  localparam logic [15:0] GAIN_P_RST      = 16'd10650;
  localparam logic [15:0] GAIN_I_RST      = 16'd5325;
  localparam logic [15:0] GAIN_D_RST      = 16'd41;
  localparam logic [30:0] MAX_SEGMENT_RST = 31'd45875;
  localparam logic [15:0] DEADBAND_RST    = 16'd655;

  localparam int MUL_W   = 64;
  localparam int MUL_B_W = 16;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 16;

  localparam logic [15:0] DERIV_SCALE = 16'd1000;
  localparam logic [15:0] INT_SCALE   = 16'd1000;
  localparam logic [49:0] U_LIMIT     = 50'd16384;
  localparam logic [47:0] INT_SAT     = 48'h7FFF_FFFF_FFFF;

  localparam logic REQ_TARGET = 1'b1;

  typedef enum logic [2:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_MAX_SEGMENT = 3'd3,
    CFG_DEADBAND    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC,
    S_BAND,
    S_INTEG,
    S_DIFF,
    S_DERIV,
    S_PROP,
    S_IMUL,
    S_IDIV,
    S_DMUL,
    S_UOUT,
    S_DUTY,
    S_FINISH
  } state_t;

endpackage

>>> hw/rtl/segmented_pid_position_controller.sv
// Segmented PID position controller, one item in flight at a time.
// A target transaction goes straight to its result. A control tick runs seven 16-bit
// serial multiplies and two 64-bit serial divides one after another; a tick inside the
// settle band stops after its first multiply. Output stalls hold the sequencer only
// while a result waits.
// Synchronous reset restores register defaults, clears goal, integral and last error, holds brake.
module segmented_pid_position_controller import spc_pkg::*; #(
  parameter int unsigned DUTY_MAX = SPC_DUTY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] measured_position,
  input  logic [15:0] elapsed_ms,
  input  logic [31:0] target_delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  duty_a,
  output logic [9:0]  duty_b,
  output logic        duty_write,
  output logic        braking,
  output logic        counter_reset,
  output logic [31:0] remaining_target
);

  localparam logic [15:0] DUTY_MAX_W = 16'(DUTY_MAX);

  state_t state, state_next;

  logic [15:0] gain_p, gain_i, gain_d, deadband_ratio;
  logic [30:0] max_segment;

  logic [31:0] remaining_goal;
  logic [47:0] integral_sum;
  logic [31:0] previous_error;
  logic        brake_held;

  logic        is_target;
  logic [15:0] ms;
  logic [31:0] delta;
  logic [31:0] seg;
  logic [33:0] err;
  logic        neg;
  logic [45:0] deriv;
  logic [63:0] acc;
  logic        u_zero;
  logic        u_pos;
  logic [14:0] u_mag;
  logic [15:0] duty;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_p;
  logic [15:0] mul_b;
  logic        div_start, div_done;
  logic [63:0] div_n, div_q;
  logic [15:0] div_d;

  logic        accept;
  logic        out_free;
  logic [31:0] lim, seg_c;
  logic [33:0] err_c;
  logic [31:0] err_mag;
  logic [63:0] p_mag;
  logic [34:0] diff;
  logic [50:0] isum;
  logic [47:0] isat;
  logic [31:0] err_sat;
  logic [63:0] acc_mag;
  logic [49:0] acc_shr;
  logic [32:0] tsum;
  logic [31:0] goal_tgt, goal_seg;
  logic        in_band;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !(out_valid && out_stall);

  spc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  spc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(div_d),
    .done(div_done), .q(div_q)
  );

  // segment clamp and error at accept
  always_comb begin
    lim = {1'b0, max_segment};
    if ($signed(remaining_goal) > $signed(lim)) begin
      seg_c = lim;
    end else if ($signed(remaining_goal) < -$signed(lim)) begin
      seg_c = -lim;
    end else begin
      seg_c = remaining_goal;
    end
    err_c = {{2{seg_c[31]}}, seg_c} - {{2{measured_position[31]}}, measured_position};
  end

  always_comb begin
    logic [33:0] em;
    em      = err[33] ? -err : err;
    err_mag = em[31:0];
    p_mag   = mul_p[63] ? -mul_p : mul_p;
    in_band = {1'b0, err_mag, 16'h0000} <= mul_p[48:0];
    diff    = {err[33], err} - {{3{previous_error[31]}}, previous_error};
    isum    = {{3{integral_sum[47]}}, integral_sum} + mul_p[50:0];
    if ($signed(isum) > $signed({3'b000, INT_SAT})) begin
      isat = INT_SAT;
    end else if ($signed(isum) < -$signed({3'b000, INT_SAT})) begin
      isat = -INT_SAT;
    end else begin
      isat = isum[47:0];
    end
    if ($signed(err) > $signed(34'sh0_7FFF_FFFF)) begin
      err_sat = 32'h7FFF_FFFF;
    end else if ($signed(err) < -$signed(34'sh0_8000_0000)) begin
      err_sat = 32'h8000_0000;
    end else begin
      err_sat = err[31:0];
    end
    acc_mag  = acc[63] ? -acc : acc;
    acc_shr  = acc_mag[63:14];
    tsum     = {remaining_goal[31], remaining_goal} + {delta[31], delta};
    if ($signed(tsum) > $signed(33'sh0_7FFF_FFFF)) begin
      goal_tgt = 32'h7FFF_FFFF;
    end else if ($signed(tsum) < -$signed(33'sh0_8000_0000)) begin
      goal_tgt = 32'h8000_0000;
    end else begin
      goal_tgt = tsum[31:0];
    end
    goal_seg = remaining_goal - seg;
  end

  // sequencer
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_n      = p_mag;
    div_d      = ms;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req_type == REQ_TARGET) ? S_FINISH : S_CALC;
        end
      end
      S_CALC: begin
        mul_start  = 1'b1;
        mul_a      = {33'h0, (seg[31] ? -seg[30:0] : seg[30:0])};
        mul_b      = deadband_ratio;
        state_next = S_BAND;
      end
      S_BAND: begin
        if (mul_done) begin
          if (in_band) begin
            state_next = S_FINISH;
          end else begin
            mul_start  = 1'b1;
            mul_a      = {{30{err[33]}}, err};
            mul_b      = ms;
            state_next = S_INTEG;
          end
        end
      end
      S_INTEG: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = {{29{diff[34]}}, diff};
          mul_b      = DERIV_SCALE;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_d      = ms;
          state_next = S_DERIV;
        end
      end
      S_DERIV: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = {{30{err[33]}}, err};
          mul_b      = gain_p;
          state_next = S_PROP;
        end
      end
      S_PROP: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = {{16{integral_sum[47]}}, integral_sum};
          mul_b      = gain_i;
          state_next = S_IMUL;
        end
      end
      S_IMUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_d      = INT_SCALE;
          state_next = S_IDIV;
        end
      end
      S_IDIV: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = {{18{deriv[45]}}, deriv};
          mul_b      = gain_d;
          state_next = S_DMUL;
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          state_next = S_UOUT;
        end
      end
      S_UOUT: begin
        mul_start  = 1'b1;
        mul_a      = (acc_shr > U_LIMIT) ? 64'(U_LIMIT) : {14'h0, acc_shr};
        mul_b      = DUTY_MAX_W;
        state_next = S_DUTY;
      end
      S_DUTY: begin
        if (mul_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      max_segment    <= MAX_SEGMENT_RST;
      deadband_ratio <= DEADBAND_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_P:      gain_p         <= cfg_data[15:0];
        CFG_GAIN_I:      gain_i         <= cfg_data[15:0];
        CFG_GAIN_D:      gain_d         <= cfg_data[15:0];
        CFG_MAX_SEGMENT: max_segment    <= cfg_data;
        CFG_DEADBAND:    deadband_ratio <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          is_target <= (req_type == REQ_TARGET);
          ms        <= (elapsed_ms == 16'h0000) ? 16'h0001 : elapsed_ms;
          delta     <= target_delta;
          seg       <= seg_c;
          err       <= err_c;
        end
      end
      S_BAND: begin
        if (mul_done) begin
          u_zero <= 1'b1;
        end
      end
      S_DIFF: begin
        if (mul_done) begin
          neg <= mul_p[63];
        end
      end
      S_DERIV: begin
        if (div_done) begin
          deriv <= neg ? -div_q[45:0] : div_q[45:0];
        end
      end
      S_PROP: begin
        if (mul_done) begin
          acc <= mul_p;
        end
      end
      S_IMUL: begin
        if (mul_done) begin
          neg <= mul_p[63];
        end
      end
      S_IDIV: begin
        if (div_done) begin
          acc <= acc + (neg ? -div_q : div_q);
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          acc <= acc + mul_p;
        end
      end
      S_UOUT: begin
        u_zero <= (acc_shr == 50'h0);
        u_pos  <= !acc[63];
        u_mag  <= (acc_shr > U_LIMIT) ? U_LIMIT[14:0] : acc_shr[14:0];
      end
      S_DUTY: begin
        if (mul_done) begin
          duty <= (mul_p[45:14] > {16'h0, DUTY_MAX_W}) ? DUTY_MAX_W : mul_p[29:14];
        end
      end
      default: ;
    endcase
  end

  // controller state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_goal <= '0;
      integral_sum   <= '0;
      previous_error <= '0;
      brake_held     <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_BAND && mul_done && in_band) begin
        integral_sum   <= '0;
        previous_error <= '0;
      end
      if (state == S_INTEG && mul_done) begin
        integral_sum <= isat;
      end
      if (state == S_DIFF && mul_done) begin
        previous_error <= err_sat;
      end
      if (state == S_FINISH && out_free) begin
        out_valid     <= 1'b1;
        duty_a        <= '0;
        duty_b        <= '0;
        duty_write    <= 1'b0;
        counter_reset <= 1'b0;
        braking       <= brake_held;
        if (is_target) begin
          remaining_goal   <= goal_tgt;
          remaining_target <= goal_tgt;
          duty_write       <= brake_held;
          brake_held       <= 1'b0;
          braking          <= 1'b0;
        end else begin
          remaining_target <= remaining_goal;
          if (u_zero && !brake_held) begin
            remaining_goal   <= goal_seg;
            remaining_target <= goal_seg;
            counter_reset    <= 1'b1;
            duty_write       <= 1'b1;
            brake_held       <= (goal_seg == 32'h0);
            braking          <= (goal_seg == 32'h0);
            if (goal_seg == 32'h0) begin
              duty_a <= DUTY_MAX_W[9:0];
              duty_b <= DUTY_MAX_W[9:0];
            end
          end else if (!brake_held) begin
            duty_write <= 1'b1;
            if (u_pos) begin
              duty_a <= duty[9:0];
            end else begin
              duty_b <= duty[9:0];
            end
          end
        end
      end
    end
  end

  // clamped output magnitude never exceeds one
  logic u_mag_ok;
  assign u_mag_ok = (u_mag <= U_LIMIT[14:0]);

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiply and divide launched together");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer idle after accepted transaction");

  a_reset_writes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counter_reset) |-> duty_write)
    else $error("counter reset without duty write");

  a_brake_duties: assert property (@(posedge clk) disable iff (rst)
    (out_valid && braking && duty_write) |-> (duty_a == duty_b))
    else $error("brake applied with unequal duties");

  a_u_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUTY) |-> u_mag_ok)
    else $error("output magnitude beyond one");

endmodule

>>> hw/rtl/spc_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned 16-bit
// multiplier, one multiplier bit per cycle, MSB first. Depends on spc_pkg.
module spc_mul import spc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_W-1:0]   p
);

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_W-1:0]   aa;
  logic [MUL_B_W-1:0] bq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      aa <= a;
      bq <= b;
      p  <= '0;
    end else if (busy) begin
      p  <= {p[MUL_W-2:0], 1'b0} + (bq[MUL_B_W-1] ? aa : '0);
      bq <= {bq[MUL_B_W-2:0], 1'b0};
    end
  end

endmodule

>>> hw/rtl/spc_div.sv
// Bit-serial restoring divider: unsigned 64-bit dividend by nonzero 16-bit
// divisor, one quotient bit per cycle. Depends on spc_pkg.
module spc_div import spc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] n,
  input  logic [DIV_D_W-1:0] d,
  output logic               done,
  output logic [DIV_N_W-1:0] q
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] dd;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   r2;
  logic [DIV_D_W:0]   sub;
  logic               ge;

  assign r2  = {rem, q[DIV_N_W-1]};
  assign sub = r2 - {1'b0, dd};
  assign ge  = r2 >= {1'b0, dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dd  <= d;
      rem <= '0;
      q   <= n;
    end else if (busy) begin
      rem <= ge ? sub[DIV_D_W-1:0] : r2[DIV_D_W-1:0];
      q   <= {q[DIV_N_W-2:0], ge};
    end
  end

endmodule

>>> tb/sv/tb_segmented_pid_position_controller.sv
// Self-checking bench for segmented_pid_position_controller: a local PID predictor
// drives expectations, stimulus is directed then random ticks and target moves.
// Depends on spc_pkg and the controller RTL.
module tb_segmented_pid_position_controller;
  import spc_pkg::*;

  localparam int DMAX = SPC_DUTY_MAX_DEF;
  localparam longint SAT47 = 64'sd140737488355327;
  localparam longint LIM_CYCLES = 2000000;

  typedef struct packed {
    logic [9:0]  da;
    logic [9:0]  db;
    logic        dw;
    logic        brk;
    logic        cr;
    logic [31:0] rem;
  } ctl_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [31:0] measured_position = '0;
  logic [15:0] elapsed_ms = '0;
  logic [31:0] target_delta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] duty_a, duty_b;
  logic duty_write, braking, counter_reset;
  logic [31:0] remaining_target;

  segmented_pid_position_controller i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  longint kp, ki, kd, seg_lim, band;
  longint goal, integ, last_err;
  bit brake;
  ctl_result_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;
  bit out_quiet = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic predict_reset();
    kp = longint'(GAIN_P_RST); ki = longint'(GAIN_I_RST); kd = longint'(GAIN_D_RST);
    seg_lim = longint'(MAX_SEGMENT_RST); band = longint'(DEADBAND_RST);
    goal = 0; integ = 0; last_err = 0; brake = 1;
  endtask

  function automatic ctl_result_t predict_control(bit rt, logic [31:0] meas_v,
                                                  logic [15:0] ms_v, logic [31:0] dlt);
    ctl_result_t r;
    longint seg, e, ms, u, dv, acc, duty;
    r = '0;
    if (rt == REQ_TARGET) begin
      goal = clampl(goal + longint'($signed(dlt)), -64'sd2147483648, 64'sd2147483647);
      if (brake) begin
        r.dw = 1; brake = 0;
      end
    end else begin
      ms = (ms_v == 16'h0) ? 64'sd1 : longint'(ms_v);
      seg = clampl(goal, -seg_lim, seg_lim);
      e = seg - longint'($signed(meas_v));
      if (absl(e) * 65536 <= band * absl(seg)) begin
        integ = 0; last_err = 0; u = 0;
      end else begin
        integ = clampl(integ + e * ms, -SAT47, SAT47);
        dv = ((e - last_err) * 1000) / ms;
        last_err = clampl(e, -64'sd2147483648, 64'sd2147483647);
        acc = kp * e + (ki * integ) / 1000 + kd * dv;
        u = clampl(acc / 16384, -16384, 16384);
      end
      if (u == 0 && !brake) begin
        r.cr = 1; r.dw = 1;
        goal = longint'(int'(goal - seg));
        brake = (goal == 0);
        if (brake) begin
          r.da = DMAX[9:0]; r.db = DMAX[9:0];
        end
      end else if (!brake) begin
        duty = (absl(u) * DMAX) >>> 14;
        if (duty > DMAX) duty = longint'(DMAX);
        r.dw = 1;
        if (u > 0) r.da = duty[9:0];
        else r.db = duty[9:0];
      end
    end
    r.brk = brake;
    r.rem = goal[31:0];
    return r;
  endfunction

  task automatic send_item(bit rt, logic [31:0] meas_v, logic [15:0] ms_v,
                           logic [31:0] dlt);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    measured_position <= meas_v;
    elapsed_ms <= ms_v;
    target_delta <= dlt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_control(rt, meas_v, ms_v, dlt));
  endtask

  task automatic send_tick(logic [31:0] meas_v, logic [15:0] ms_v);
    send_item(1'b0, meas_v, ms_v, $urandom);
  endtask

  task automatic send_target(logic [31:0] dlt);
    send_item(REQ_TARGET, $urandom, 16'($urandom), dlt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_GAIN_P: kp = longint'(val[15:0]);
      CFG_GAIN_I: ki = longint'(val[15:0]);
      CFG_GAIN_D: kd = longint'(val[15:0]);
      CFG_MAX_SEGMENT: seg_lim = longint'(val);
      CFG_DEADBAND: band = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    ctl_result_t x;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        x = expected_q.pop_front();
        if (duty_a !== x.da) begin
          $error("duty_a exp %0d got %0d", x.da, duty_a); errors++;
        end
        if (duty_b !== x.db) begin
          $error("duty_b exp %0d got %0d", x.db, duty_b); errors++;
        end
        if (duty_write !== x.dw) begin
          $error("duty_write exp %0d got %0d", x.dw, duty_write); errors++;
        end
        if (braking !== x.brk) begin
          $error("braking exp %0d got %0d", x.brk, braking); errors++;
        end
        if (counter_reset !== x.cr) begin
          $error("counter_reset exp %0d got %0d", x.cr, counter_reset); errors++;
        end
        if (remaining_target !== x.rem) begin
          $error("remaining_target exp %h got %h", x.rem, remaining_target); errors++;
        end
      end
    end
    out_stall <= !out_quiet && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    if (cycles > LIM_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_tick(32'h0, 16'd0);
    send_target(32'h0001_0000);
    send_tick(32'h0, 16'd10);
    send_tick(32'h8000_0000, 16'hFFFF);
    send_tick(32'h7FFF_FFFF, 16'd1);
    send_tick(32'h0000_B333, 16'd10);
    send_tick(32'h0000_B300, 16'd10);
    send_tick(32'h0001_0000, 16'd10);
    send_target(32'h7FFF_FFFF);
    send_target(32'h7FFF_FFFF);
    send_tick(32'h0, 16'd0);
    send_target(32'h8000_0000);
    send_target(32'h8000_0000);
    send_target(32'h8000_0000);
    send_tick(32'hFFFF_0000, 16'd5);
    send_target(32'hFFFF_FFFF);
    send_tick(32'h0, 16'd10);
    send_tick(32'h0000_0001, 16'd10);
    drain();
  endtask

  task automatic test_random(int n);
    logic [31:0] m;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(3))
          0: send_target($urandom);
          default: send_target($signed($urandom_range(200000)) - 100000);
        endcase
      end else begin
        case ($urandom_range(4))
          0: m = $urandom;
          1: m = 32'(longint'($signed(remaining_target)) + $urandom_range(64) - 32);
          default: m = 32'(longint'($signed(remaining_target)) / 2
                        + $signed($urandom_range(4000)) - 2000);
        endcase
        send_tick(m, $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(20)));
      end
    end
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_GAIN_P, 31'hFFFF); write_reg(CFG_GAIN_I, 31'hFFFF);
    write_reg(CFG_GAIN_D, 31'hFFFF); write_reg(CFG_MAX_SEGMENT, 31'h7FFF_FFFF);
    write_reg(CFG_DEADBAND, 31'hFFFF);
    test_random(120);
    write_reg(CFG_GAIN_P, 31'd0); write_reg(CFG_GAIN_I, 31'd0);
    write_reg(CFG_GAIN_D, 31'd0); write_reg(CFG_MAX_SEGMENT, 31'd0);
    write_reg(CFG_DEADBAND, 31'd0);
    test_random(60);
    write_reg(CFG_GAIN_P, 31'd4096); write_reg(CFG_GAIN_I, 31'd200);
    write_reg(CFG_GAIN_D, 31'd50); write_reg(CFG_MAX_SEGMENT, 31'h0002_0000);
    write_reg(CFG_DEADBAND, 31'd3000);
    test_random(150);
  endtask

  initial begin
    predict_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    quiet = 1; out_quiet = 1;
    test_random(100);
    quiet = 0; out_quiet = 0;
    test_config_sweep();
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
